/* rtl/core/multichannel_conv2d_valid_macros.svh */
// Assertion macros for the checker module of the convolution block
`ifndef MULTICHANNEL_CONV2D_VALID_MACROS_SVH
`define MULTICHANNEL_CONV2D_VALID_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define MCC_AST_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mcconv check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define MCC_AST_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mcconv check failed");

`endif

/* rtl/core/mcconv_pkg.sv */
// Shared constants of the multi-channel convolution block
`timescale 1ns / 1ps
package mcconv_pkg;

	localparam int DEF_MAX_IN_CH  = 16;
	localparam int DEF_MAX_OUT_CH = 16;
	localparam int DEF_MAX_DIM    = 32;
	localparam int DEF_MAX_FILTER = 5;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 6;
	localparam int SUM_W      = 40;
	localparam int PROD_W     = 32;

	localparam logic [1:0] ACT_WR_WEIGHT = 2'd0;
	localparam logic [1:0] ACT_WR_SAMPLE = 2'd1;
	localparam logic [1:0] ACT_COMPUTE   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_IN_CH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_CH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FILTER  = 3'd4;

	localparam logic signed [63:0] SUM_HI = 64'sh0000_007F_FFFF_FFFF;
	localparam logic signed [63:0] SUM_LO = -64'sh0000_0080_0000_0000;

endpackage

/* rtl/core/multichannel_conv2d_valid.sv */
// Multi-channel valid 2D convolution, one output point per compute transaction.
// Writes leave the input free. A compute transaction checks its range (an error goes
// straight to the result), sets up addresses, runs one multiply-accumulate per cycle
// against one read port on each store, drains the pipeline and presents its result; the
// input is free again with the result, and a stalled earlier result holds the final step.
// Reset (arst_n, asynchronous) restores config and control registers to their defaults; stores stay.
`timescale 1ns / 1ps
module multichannel_conv2d_valid
	import mcconv_pkg::*;
#(
	parameter int MAX_IN_CH  = DEF_MAX_IN_CH,
	parameter int MAX_OUT_CH = DEF_MAX_OUT_CH,
	parameter int MAX_DIM    = DEF_MAX_DIM,
	parameter int MAX_FILTER = DEF_MAX_FILTER
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wen,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            action,
	input  logic [13:0]           addr,
	input  logic signed [15:0]    value,
	input  logic [3:0]            out_channel,
	input  logic [4:0]            out_row,
	input  logic [4:0]            out_col,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic signed [SUM_W-1:0] conv_sum,
	output logic                  range_error
);

	localparam int S_DEPTH = MAX_IN_CH * MAX_DIM * MAX_DIM;
	localparam int W_DEPTH = MAX_OUT_CH * MAX_IN_CH * MAX_FILTER * MAX_FILTER;
	localparam int SA_W    = (S_DEPTH > 1) ? $clog2(S_DEPTH) : 1;
	localparam int WA_W    = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
	localparam int CH_W    = $clog2(MAX_IN_CH + 1);
	localparam int NO_W    = $clog2(MAX_OUT_CH + 1);
	localparam int D_W     = $clog2(MAX_DIM + 1);
	localparam int F_W     = $clog2(MAX_FILTER + 1);
	localparam int FF_W    = $clog2(MAX_FILTER * MAX_FILTER + 1);
	localparam int TERMS   = MAX_IN_CH * MAX_FILTER * MAX_FILTER;
	localparam int ACC_RAW = PROD_W + $clog2(TERMS + 1);
	localparam int ACC_W   = (ACC_RAW > SUM_W) ? ACC_RAW : SUM_W;

	localparam logic signed [ACC_W-1:0] ACC_HI = ACC_W'(SUM_HI);
	localparam logic signed [ACC_W-1:0] ACC_LO = ACC_W'(SUM_LO);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHK   = 3'd1;
	localparam logic [2:0] ST_MUL   = 3'd2;
	localparam logic [2:0] ST_BASE  = 3'd3;
	localparam logic [2:0] ST_RUN   = 3'd4;
	localparam logic [2:0] ST_DRAIN = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [15:0] sample_mem [S_DEPTH];
	logic [15:0] weight_mem [W_DEPTH];

	logic [2:0]  state_q;
	logic [4:0]  in_channels_q;
	logic [4:0]  out_channels_q;
	logic [5:0]  in_height_q;
	logic [5:0]  in_width_q;
	logic [2:0]  filter_size_q;

	logic [3:0]  oc_q;
	logic [4:0]  row_q;
	logic [4:0]  col_q;
	logic        err_q;
	logic [CH_W-1:0] nc_q;
	logic [D_W-1:0]  h_q;
	logic [D_W-1:0]  w_q;
	logic [F_W-1:0]  f_q;
	logic [FF_W-1:0] ff_q;
	logic [WA_W:0]   nff_q;
	logic [SA_W:0]   hw_q;
	logic [SA_W-1:0] schan_q;
	logic [SA_W-1:0] srow_q;
	logic [WA_W-1:0] waddr_q;
	logic [CH_W-1:0] i_q;
	logic [F_W-1:0]  fh_q;
	logic [F_W-1:0]  fw_q;

	logic        vld_s1;
	logic [15:0] sdata_s1;
	logic [15:0] wdata_s1;
	logic        vld_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;

	logic        out_valid_q;
	logic signed [SUM_W-1:0] conv_sum_q;
	logic        range_error_q;

	logic [CH_W-1:0] nc_c;
	logic [NO_W-1:0] no_c;
	logic [D_W-1:0]  h_c;
	logic [D_W-1:0]  w_c;
	logic [F_W-1:0]  f_c;
	logic        err_c;
	logic        in_acc;
	logic        rd_en;
	logic [SA_W-1:0] saddr;
	logic        last_fw;
	logic        last_fh;
	logic        last_i;
	logic        out_free;
	logic signed [SUM_W-1:0] sat_sum;

	assign in_stall    = (state_q != ST_IDLE);
	assign in_acc      = in_valid && !in_stall;
	assign out_valid   = out_valid_q;
	assign conv_sum    = conv_sum_q;
	assign range_error = range_error_q;
	assign out_free    = !out_valid_q || !out_stall;

	always_comb begin
		nc_c = (in_channels_q == 5'd0) ? CH_W'(1) :
			(32'(in_channels_q) > 32'(MAX_IN_CH)) ? CH_W'(MAX_IN_CH) : CH_W'(in_channels_q);
		no_c = (out_channels_q == 5'd0) ? NO_W'(1) :
			(32'(out_channels_q) > 32'(MAX_OUT_CH)) ? NO_W'(MAX_OUT_CH) : NO_W'(out_channels_q);
		h_c = (in_height_q == 6'd0) ? D_W'(1) :
			(32'(in_height_q) > 32'(MAX_DIM)) ? D_W'(MAX_DIM) : D_W'(in_height_q);
		w_c = (in_width_q == 6'd0) ? D_W'(1) :
			(32'(in_width_q) > 32'(MAX_DIM)) ? D_W'(MAX_DIM) : D_W'(in_width_q);
		f_c = (filter_size_q == 3'd0) ? F_W'(1) :
			(32'(filter_size_q) > 32'(MAX_FILTER)) ? F_W'(MAX_FILTER) : F_W'(filter_size_q);
		err_c = (32'(oc_q) >= 32'(no_c)) || (32'(f_c) > 32'(h_c)) || (32'(f_c) > 32'(w_c))
			|| (32'(row_q) > 32'(h_c) - 32'(f_c)) || (32'(col_q) > 32'(w_c) - 32'(f_c));
	end

	assign rd_en   = (state_q == ST_RUN);
	assign saddr   = srow_q + SA_W'(fw_q);
	assign last_fw = (fw_q == f_q - F_W'(1));
	assign last_fh = (fh_q == f_q - F_W'(1));
	assign last_i  = (i_q == nc_q - CH_W'(1));

	always_comb begin
		if (acc_q > ACC_HI) begin
			sat_sum = SUM_W'(ACC_HI);
		end else if (acc_q < ACC_LO) begin
			sat_sum = SUM_W'(ACC_LO);
		end else begin
			sat_sum = SUM_W'(acc_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_channels_q  <= 5'd1;
			out_channels_q <= 5'd6;
			in_height_q    <= 6'd32;
			in_width_q     <= 6'd32;
			filter_size_q  <= 3'd5;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				CFG_IN_CH:  in_channels_q  <= cfg_data[4:0];
				CFG_OUT_CH: out_channels_q <= cfg_data[4:0];
				CFG_HEIGHT: in_height_q    <= cfg_data;
				CFG_WIDTH:  in_width_q     <= cfg_data;
				CFG_FILTER: filter_size_q  <= cfg_data[2:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && action == ACT_WR_SAMPLE && 32'(addr) < 32'(S_DEPTH)) begin
			sample_mem[SA_W'(addr)] <= value;
		end
		sdata_s1 <= sample_mem[saddr];
	end

	always_ff @(posedge clk) begin
		if (in_acc && action == ACT_WR_WEIGHT && 32'(addr) < 32'(W_DEPTH)) begin
			weight_mem[WA_W'(addr)] <= value;
		end
		wdata_s1 <= weight_mem[waddr_q];
	end

	always_ff @(posedge clk) begin
		prod_s2 <= $signed(sdata_s1) * $signed(wdata_s1);
		unique case (state_q)
			ST_IDLE: begin
				oc_q  <= out_channel;
				row_q <= out_row;
				col_q <= out_col;
			end
			ST_CHK: begin
				err_q <= err_c;
				nc_q  <= nc_c;
				h_q   <= h_c;
				w_q   <= w_c;
				f_q   <= f_c;
				ff_q  <= FF_W'(f_c) * FF_W'(f_c);
			end
			ST_MUL: begin
				nff_q   <= (WA_W + 1)'(nc_q) * (WA_W + 1)'(ff_q);
				hw_q    <= (SA_W + 1)'(h_q) * (SA_W + 1)'(w_q);
				schan_q <= SA_W'(SA_W'(row_q) * SA_W'(w_q) + SA_W'(col_q));
			end
			ST_BASE: begin
				waddr_q <= WA_W'((WA_W + 1)'(oc_q) * nff_q);
				srow_q  <= schan_q;
				i_q     <= '0;
				fh_q    <= '0;
				fw_q    <= '0;
			end
			ST_RUN: begin
				waddr_q <= waddr_q + WA_W'(1);
				if (!last_fw) begin
					fw_q <= fw_q + F_W'(1);
				end else begin
					fw_q <= '0;
					if (!last_fh) begin
						fh_q   <= fh_q + F_W'(1);
						srow_q <= srow_q + SA_W'(w_q);
					end else begin
						fh_q    <= '0;
						i_q     <= i_q + CH_W'(1);
						srow_q  <= SA_W'(schan_q + hw_q);
						schan_q <= SA_W'(schan_q + hw_q);
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			acc_q   <= '0;
		end else begin
			vld_s1 <= rd_en;
			vld_s2 <= vld_s1;
			if (state_q == ST_BASE) begin
				acc_q <= '0;
			end else if (vld_s2) begin
				acc_q <= acc_q + ACC_W'(prod_s2);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && action == ACT_COMPUTE) begin
						state_q <= ST_CHK;
					end
				end
				ST_CHK:  state_q <= err_c ? ST_DONE : ST_MUL;
				ST_MUL:  state_q <= ST_BASE;
				ST_BASE: state_q <= ST_RUN;
				ST_RUN: begin
					if (last_fw && last_fh && last_i) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!vld_s1 && !vld_s2) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			conv_sum_q    <= err_q ? '0 : sat_sum;
			range_error_q <= err_q;
		end
	end

endmodule

/* rtl/core/mcconv_chk.sv */
// Port checker for the multi-channel convolution block, bound to the top level
`timescale 1ns / 1ps
`include "multichannel_conv2d_valid_macros.svh"
module mcconv_chk
	import mcconv_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic [1:0]            action,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic signed [SUM_W-1:0] conv_sum,
	input logic                  range_error
);

	`MCC_AST_NXT(a_out_hold, out_valid && out_stall, out_valid)
	`MCC_AST_NXT(a_out_stable, out_valid && out_stall, $stable(conv_sum) && $stable(range_error))
	`MCC_AST_IMP(a_err_zero, out_valid && range_error, conv_sum == '0)
	`MCC_AST_NXT(a_busy_after_compute, in_valid && !in_stall && action == ACT_COMPUTE, in_stall)
	`MCC_AST_NXT(a_free_after_write, in_valid && !in_stall && action != ACT_COMPUTE, !in_stall)

endmodule

bind multichannel_conv2d_valid mcconv_chk u_mcconv_chk (.*);
